### hdl/bba_pkg.sv
// Block bitmap allocator: shared payload types, status and function codes,
// controller state type. No dependencies.
`timescale 1ns / 1ps

package bba_pkg;

  localparam int unsigned NUM_W  = 13;
  localparam int unsigned STAT_W = 2;

  localparam logic [NUM_W-1:0] BLOCK_COUNT_RST = 13'd4096;

  // request function codes
  localparam logic FUNC_ALLOC = 1'b0;
  localparam logic FUNC_FREE  = 1'b1;

  // response status codes
  localparam logic [STAT_W-1:0] STAT_OK   = 2'd0;
  localparam logic [STAT_W-1:0] STAT_FULL = 2'd1;
  localparam logic [STAT_W-1:0] STAT_BAD  = 2'd2;

  typedef struct packed {
    logic             func;
    logic [NUM_W-1:0] block_number;
  } req_t;

  typedef struct packed {
    logic [NUM_W-1:0]  granted_block;
    logic [STAT_W-1:0] status;
  } rsp_t;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_SCAN,
    ST_FDIV,
    ST_FRD,
    ST_FWR,
    ST_RESP
  } state_e;

endpackage

### hdl/bba_map_ram.sv
// Usage map storage: one-write, one-read synchronous RAM, registered read data.
// No package dependencies.
`timescale 1ns / 1ps

module bba_map_ram #(
  parameter int DEPTH = 128,
  parameter int WIDTH = 32,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AW-1:0]    waddr_i,
  input  logic [WIDTH-1:0] wdata_i,
  input  logic             re_i,
  input  logic [AW-1:0]    raddr_i,
  output logic [WIDTH-1:0] rdata_o
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### hdl/bba_word_search.sv
// Find-first-free search over one map word, limited to the low lim_i bits.
// No package dependencies.
`timescale 1ns / 1ps

module bba_word_search #(
  parameter int WORD_BITS = 32,
  parameter int BW        = $clog2(WORD_BITS),
  parameter int LW        = $clog2(WORD_BITS + 1)
) (
  input  logic [WORD_BITS-1:0] word_i,
  input  logic [LW-1:0]        lim_i,
  output logic                 found_o,
  output logic [BW-1:0]        idx_o
);

  logic [WORD_BITS-1:0] avail;

  always_comb begin
    for (int j = 0; j < WORD_BITS; j++) begin
      avail[j] = !word_i[j] && (lim_i > LW'(j));
    end
  end

  // lowest free bit wins
  always_comb begin
    idx_o = '0;
    for (int j = WORD_BITS - 1; j >= 0; j--) begin
      if (avail[j]) begin
        idx_o = BW'(j);
      end
    end
  end

  assign found_o = |avail;

endmodule

### hdl/block_bitmap_allocator_core.sv
// First-fit block allocator over a one-bit-per-block usage map.
// Request channel (req_valid_i/req_ready_o, req_i): func selects allocate or
// free; block_number is the 1-based block to free. Response channel
// (rsp_valid_o/rsp_ready_i, rsp_o): one response per request, in order, with
// granted_block (1-based, 0 when none) and status (ok, map full, bad number).
// cfg_we_i/cfg_wdata_i write block_count; write it only while idle.
// The map sits in a RAM of ceil(BLOCKS/WORD_BITS) words; an allocate reads one
// word per cycle, from the first word on, up to ceil(count/WORD_BITS) words,
// until a word holds a free bit, which it sets and writes back; if none does,
// the map is full. A free steps through divide, read, write back, response; a
// bad number goes straight to the response.
// One request is worked at a time; a new one is taken as soon as the previous
// has left for the output register.
// After reset the map RAM is cleared one word per cycle, with req_ready_o
// low; block_count resets to 4096.
// When the receiver stalls the response waits in the output register; the
// next request is still taken and its response waits until the slot frees.
`timescale 1ns / 1ps

module block_bitmap_allocator_core #(
  parameter int BLOCKS    = 4096,
  parameter int WORD_BITS = 32
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        req_valid_i,
  output logic                        req_ready_o,
  input  bba_pkg::req_t               req_i,
  output logic                        rsp_valid_o,
  input  logic                        rsp_ready_i,
  output bba_pkg::rsp_t               rsp_o,
  input  logic                        cfg_we_i,
  input  logic [bba_pkg::NUM_W-1:0]   cfg_wdata_i
);

  import bba_pkg::*;

  localparam int MAP_WORDS = (BLOCKS + WORD_BITS - 1) / WORD_BITS;
  localparam int AW        = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
  localparam int BW        = $clog2(WORD_BITS);
  localparam int LW        = $clog2(WORD_BITS + 1);
  localparam int CW        = $clog2(BLOCKS + WORD_BITS + 1);
  // reciprocal for word index = (block - 1) / WORD_BITS over NUM_W-bit values
  localparam int DIV_S     = NUM_W + $clog2(WORD_BITS);
  localparam logic [31:0] DIV_M = 32'(((64'd1 << DIV_S) + WORD_BITS - 1) / WORD_BITS);
  localparam logic [WORD_BITS-1:0] ONE_W = {{(WORD_BITS - 1){1'b0}}, 1'b1};

  state_e              state_q, state_d;
  logic [NUM_W-1:0]    block_count_q;
  logic [AW-1:0]       clr_w_q, clr_w_d;
  logic [AW-1:0]       iss_w_q, iss_w_d;
  logic [CW-1:0]       iss_base_q, iss_base_d;
  logic                ev_vld_q, ev_vld_d;
  logic [AW-1:0]       ev_w_q, ev_w_d;
  logic [CW-1:0]       ev_base_q, ev_base_d;
  logic [NUM_W-1:0]    x_q, x_d;
  logic [AW-1:0]       q_q, q_d;
  logic [BW-1:0]       bit_q, bit_d;
  rsp_t                res_q, res_d;
  logic                out_valid_q;
  rsp_t                out_q;
  logic                out_load;

  logic                map_we, map_re;
  logic [AW-1:0]       map_waddr, map_raddr;
  logic [WORD_BITS-1:0] map_wdata, map_rdata;

  logic [31:0]         cnt_wide;
  logic [CW-1:0]       cnt;
  logic [CW-1:0]       rem;
  logic [LW-1:0]       lim;
  logic                fz_found;
  logic [BW-1:0]       fz_idx;
  logic [31:0]         grant_wide;
  logic [31:0]         prod;
  logic [31:0]         bit_wide;
  logic                free_bad;

  // effective count saturates at the map size
  assign cnt_wide = ({{(32 - NUM_W){1'b0}}, block_count_q} > 32'(BLOCKS)) ?
                    32'(BLOCKS) : {{(32 - NUM_W){1'b0}}, block_count_q};
  assign cnt      = cnt_wide[CW-1:0];
  assign rem      = cnt - ev_base_q;
  assign lim      = (rem >= CW'(WORD_BITS)) ? LW'(WORD_BITS) : LW'(rem);
  assign grant_wide = 32'(ev_base_q) + 32'(fz_idx) + 32'd1;
  assign prod     = 32'(x_q) * DIV_M;
  assign bit_wide = 32'(x_q) - 32'(q_q) * 32'(WORD_BITS);
  assign free_bad = (req_i.block_number == '0) ||
                    ({{(32 - NUM_W){1'b0}}, req_i.block_number} > cnt_wide);

  bba_map_ram #(
    .DEPTH (MAP_WORDS),
    .WIDTH (WORD_BITS),
    .AW    (AW)
  ) u_map_ram (
    .clk_i   (clk_i),
    .we_i    (map_we),
    .waddr_i (map_waddr),
    .wdata_i (map_wdata),
    .re_i    (map_re),
    .raddr_i (map_raddr),
    .rdata_o (map_rdata)
  );

  bba_word_search #(
    .WORD_BITS (WORD_BITS),
    .BW        (BW),
    .LW        (LW)
  ) u_word_search (
    .word_i  (map_rdata),
    .lim_i   (lim),
    .found_o (fz_found),
    .idx_o   (fz_idx)
  );

  always_comb begin
    state_d    = state_q;
    clr_w_d    = clr_w_q;
    iss_w_d    = iss_w_q;
    iss_base_d = iss_base_q;
    ev_vld_d   = 1'b0;
    ev_w_d     = ev_w_q;
    ev_base_d  = ev_base_q;
    x_d        = x_q;
    q_d        = q_q;
    bit_d      = bit_q;
    res_d      = res_q;
    out_load   = 1'b0;
    map_we     = 1'b0;
    map_waddr  = clr_w_q;
    map_wdata  = '0;
    map_re     = 1'b0;
    map_raddr  = iss_w_q;
    req_ready_o = 1'b0;

    case (state_q)
      ST_CLEAR: begin
        map_we = 1'b1;
        if (clr_w_q == AW'(MAP_WORDS - 1)) begin
          state_d = ST_IDLE;
        end else begin
          clr_w_d = clr_w_q + AW'(1);
        end
      end
      ST_IDLE: begin
        req_ready_o = 1'b1;
        if (req_valid_i) begin
          if (req_i.func == FUNC_FREE) begin
            x_d = req_i.block_number - NUM_W'(1);
            if (free_bad) begin
              res_d   = '{granted_block: '0, status: STAT_BAD};
              state_d = ST_RESP;
            end else begin
              state_d = ST_FDIV;
            end
          end else begin
            iss_w_d    = '0;
            iss_base_d = '0;
            state_d    = ST_SCAN;
          end
        end
      end
      ST_SCAN: begin
        if (ev_vld_q && fz_found) begin
          // claim the bit and write the word back
          map_we    = 1'b1;
          map_waddr = ev_w_q;
          map_wdata = map_rdata | (ONE_W << fz_idx);
          res_d     = '{granted_block: grant_wide[NUM_W-1:0], status: STAT_OK};
          state_d   = ST_RESP;
        end else if (iss_base_q < cnt) begin
          map_re     = 1'b1;
          ev_vld_d   = 1'b1;
          ev_w_d     = iss_w_q;
          ev_base_d  = iss_base_q;
          iss_w_d    = iss_w_q + AW'(1);
          iss_base_d = iss_base_q + CW'(WORD_BITS);
        end else if (!ev_vld_q) begin
          res_d   = '{granted_block: '0, status: STAT_FULL};
          state_d = ST_RESP;
        end
      end
      ST_FDIV: begin
        q_d     = AW'(prod >> DIV_S);
        state_d = ST_FRD;
      end
      ST_FRD: begin
        map_re    = 1'b1;
        map_raddr = q_q;
        bit_d     = bit_wide[BW-1:0];
        state_d   = ST_FWR;
      end
      ST_FWR: begin
        map_we    = 1'b1;
        map_waddr = q_q;
        map_wdata = map_rdata & ~(ONE_W << bit_q);
        res_d     = '{granted_block: '0, status: STAT_OK};
        state_d   = ST_RESP;
      end
      ST_RESP: begin
        // hold until the output register is free
        if (!out_valid_q || rsp_ready_i) begin
          out_load = 1'b1;
          state_d  = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q       <= ST_CLEAR;
      clr_w_q       <= '0;
      ev_vld_q      <= 1'b0;
      out_valid_q   <= 1'b0;
      block_count_q <= BLOCK_COUNT_RST;
    end else begin
      state_q  <= state_d;
      clr_w_q  <= clr_w_d;
      ev_vld_q <= ev_vld_d;
      if (out_load) begin
        out_valid_q <= 1'b1;
      end else if (rsp_ready_i) begin
        out_valid_q <= 1'b0;
      end
      if (cfg_we_i) begin
        block_count_q <= cfg_wdata_i;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    iss_w_q    <= iss_w_d;
    iss_base_q <= iss_base_d;
    ev_w_q     <= ev_w_d;
    ev_base_q  <= ev_base_d;
    x_q        <= x_d;
    q_q        <= q_d;
    bit_q      <= bit_d;
    res_q      <= res_d;
    if (out_load) begin
      out_q <= res_q;
    end
  end

  assign rsp_valid_o = out_valid_q;
  assign rsp_o       = out_q;

`ifndef SYNTH
  a_no_rw_same_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (map_we && map_re) |-> (map_waddr != map_raddr))
    else $error("map read and write to the same word in one cycle");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (req_valid_i && req_ready_o) |=> (state_q != ST_IDLE))
    else $error("request accepted but controller stayed idle");

  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_q && !rsp_ready_i) |=> ($stable(out_q) && out_valid_q))
    else $error("stalled response overwritten");

  a_fail_no_grant: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rsp_valid_o && (rsp_o.status == STAT_FULL || rsp_o.status == STAT_BAD))
      |-> (rsp_o.granted_block == '0))
    else $error("failed request carries a block number");
`endif

endmodule
